[hdl/nfc_pkg.sv]
// ----------------------------------------------------------------------------
// nfc_pkg
// Format codes, exponent window constants and exponent test helpers shared
// by the numeric format classifier.
// ----------------------------------------------------------------------------
package nfc_pkg;

   // Dense format codes
   localparam logic [3:0] FMT_UNKNOWN = 4'd0;
   localparam logic [3:0] FMT_LE2     = 4'd1;
   localparam logic [3:0] FMT_LE4     = 4'd2;
   localparam logic [3:0] FMT_HE2     = 4'd3;
   localparam logic [3:0] FMT_HE4     = 4'd4;
   localparam logic [3:0] FMT_LF4     = 4'd5;
   localparam logic [3:0] FMT_HF4     = 4'd6;
   localparam logic [3:0] FMT_VAXF    = 4'd7;
   localparam logic [3:0] FMT_LF8     = 4'd8;
   localparam logic [3:0] FMT_HF8     = 4'd9;
   localparam logic [3:0] FMT_VAXG    = 4'd10;

   // Plausible exponent window: bias - 3 < e < bias + 20
   localparam int EXP4_BIAS  = 127;
   localparam int EXP8_BIAS  = 1023;
   localparam int EXP_LO_OFS = 3;
   localparam int EXP_HI_OFS = 20;

   localparam logic [7:0]  EXP4_LO = 8'(EXP4_BIAS - EXP_LO_OFS);
   localparam logic [7:0]  EXP4_HI = 8'(EXP4_BIAS + EXP_HI_OFS);
   localparam logic [10:0] EXP8_LO = 11'(EXP8_BIAS - EXP_LO_OFS);
   localparam logic [10:0] EXP8_HI = 11'(EXP8_BIAS + EXP_HI_OFS);

   // 4-byte float: exponent in bits 14:7 of the sign/exponent half
   function automatic logic plaus4(input logic [15:0] half);
      logic [7:0] e;
      e = half[14:7];
      return (e > EXP4_LO) && (e < EXP4_HI);
   endfunction

   // 8-byte float: exponent in bits 14:4 of the sign/exponent half
   function automatic logic plaus8(input logic [15:0] half);
      logic [10:0] e;
      e = half[14:4];
      return (e > EXP8_LO) && (e < EXP8_HI);
   endfunction

endpackage

[hdl/numeric_format_classifier.sv]
// Path: a request marked last_item reaches rsp_ as a format code after passing the
// input register, the accumulate/snapshot register and the result register, in that order.
// Throughput: one doubleword per cycle; a stalled result holds back the next last_item in the
// input register and every request behind it, while ordinary doublewords keep flowing in.
// Reset: synchronous, active high; clears the running sums, counters and valid flags.
// ----------------------------------------------------------------------------
// numeric_format_classifier
// Streams a buffer as 8-byte doublewords, accumulates byte-lane sums and
// plausible-exponent counters, and on the last doubleword emits a guess of
// the buffer's numeric encoding as a dense format code.
// ----------------------------------------------------------------------------
module numeric_format_classifier #(
   parameter int MAX_DOUBLEWORDS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_first_word,
   input  logic [31:0] req_second_word,
   input  logic        req_last_item,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_format_code
);

   // Widths follow from the doubleword limit:
   //   count  holds 0..MAX
   //   lane   sums two bytes per doubleword
   //   single counters see two 4-byte words per doubleword
   localparam int CNT_W  = $clog2(MAX_DOUBLEWORDS + 1);
   localparam int SUM_W  = $clog2(510 * MAX_DOUBLEWORDS + 1);
   localparam int SGL_W  = $clog2(2 * MAX_DOUBLEWORDS + 1);
   localparam int WIDE_W = SUM_W + 12;   // room for a lane sum shifted by 12
   localparam int LIM_W  = CNT_W + 2;    // room for 3 * (count >> 1)

   // ------------------------------------------------------------------
   // Stage 1: input register
   // ------------------------------------------------------------------
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_w0_ff, s1_w1_ff;
   logic        s1_last_ff;

   // Stage 2: accumulators and snapshot of a finished buffer
   logic [SUM_W-1:0] lane_ff [4];
   logic [SUM_W-1:0] lane_in [4];
   logic [SGL_W-1:0] sgl_ff  [3];
   logic [SGL_W-1:0] sgl_in  [3];
   logic [CNT_W-1:0] dbl_ff  [3];
   logic [CNT_W-1:0] dbl_in  [3];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             snap_valid_ff, snap_valid_in;
   logic [SUM_W-1:0] snap_lane_ff [4];
   logic [SGL_W-1:0] snap_sgl_ff  [3];
   logic [CNT_W-1:0] snap_dbl_ff  [3];
   logic [CNT_W-1:0] snap_cnt_ff;

   // Stage 3: result register
   logic       out_valid_ff, out_valid_in;
   logic [3:0] out_code_ff, out_code_in;

   // ------------------------------------------------------------------
   // Flow control: each stage advances when the slot below it frees up
   // ------------------------------------------------------------------
   logic out_load;   // result register may take a new code
   logic snap_free;  // snapshot slot free or emptying this cycle
   logic s1_go;      // stage 1 request gets processed this cycle
   logic s1_load;    // stage 1 may take a new request

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign snap_free = !snap_valid_ff || out_load;
   assign s1_go     = s1_valid_ff && (!s1_last_ff || snap_free);
   assign s1_load   = !s1_valid_ff || s1_go;

   assign req_stall       = !s1_load;
   assign rsp_valid       = out_valid_ff;
   assign rsp_format_code = out_code_ff;

   // ------------------------------------------------------------------
   // Per-doubleword contributions
   // ------------------------------------------------------------------
   logic       counting;
   logic [8:0] byte_sum [4];
   logic [1:0] sgl_inc  [3];
   logic       dbl_hit  [3];

   always_comb begin
      counting = (cnt_ff < CNT_W'(MAX_DOUBLEWORDS));
      for (int k = 0; k < 4; k++) begin
         byte_sum[k] = {1'b0, s1_w0_ff[8*k +: 8]} + {1'b0, s1_w1_ff[8*k +: 8]};
      end
      // little-endian IEEE: sign/exponent half in bytes 3,2
      sgl_inc[0] = {1'b0, nfc_pkg::plaus4(s1_w0_ff[31:16])}
                 + {1'b0, nfc_pkg::plaus4(s1_w1_ff[31:16])};
      // big-endian IEEE: sign/exponent half in bytes 0,1
      sgl_inc[1] = {1'b0, nfc_pkg::plaus4({s1_w0_ff[7:0], s1_w0_ff[15:8]})}
                 + {1'b0, nfc_pkg::plaus4({s1_w1_ff[7:0], s1_w1_ff[15:8]})};
      // VAX: sign/exponent half in bytes 1,0
      sgl_inc[2] = {1'b0, nfc_pkg::plaus4(s1_w0_ff[15:0])}
                 + {1'b0, nfc_pkg::plaus4(s1_w1_ff[15:0])};
      // 8-byte: little-endian tests the upper word, the others the lower one
      dbl_hit[0] = nfc_pkg::plaus8(s1_w1_ff[31:16]);
      dbl_hit[1] = nfc_pkg::plaus8({s1_w0_ff[7:0], s1_w0_ff[15:8]});
      dbl_hit[2] = nfc_pkg::plaus8(s1_w0_ff[15:0]);
   end

   // Updated accumulator values, including the current doubleword
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lane_in[k] = counting ? lane_ff[k] + SUM_W'(byte_sum[k]) : lane_ff[k];
      end
      for (int k = 0; k < 3; k++) begin
         sgl_in[k] = counting ? sgl_ff[k] + SGL_W'(sgl_inc[k]) : sgl_ff[k];
         dbl_in[k] = counting ? dbl_ff[k] + CNT_W'(dbl_hit[k]) : dbl_ff[k];
      end
      cnt_in = counting ? cnt_ff + CNT_W'(1) : cnt_ff;
   end

   // ------------------------------------------------------------------
   // Decision tree on the snapshot
   // ------------------------------------------------------------------
   logic [WIDE_W-1:0] n1, n2, n3, n4;
   logic [LIM_W-1:0]  lim4, lim8;
   logic [5:0]        hit;
   logic [3:0]        int_code, flt_code;

   always_comb begin
      n1 = WIDE_W'(snap_lane_ff[0]);
      n2 = WIDE_W'(snap_lane_ff[1]);
      n3 = WIDE_W'(snap_lane_ff[2]);
      n4 = WIDE_W'(snap_lane_ff[3]);

      // integer endian tests: dominant high or low bytes
      int_code = nfc_pkg::FMT_UNKNOWN;
      if (n1 > (n4 << 3)) begin
         if (n3 > (n2 << 3)) begin
            int_code = nfc_pkg::FMT_LE2;
         end else if ((n1 > (n4 << 12)) && (n2 >= (n3 << 2))) begin
            int_code = nfc_pkg::FMT_LE4;
         end
      end else if (n4 > (n1 << 3)) begin
         if (n2 > (n3 << 3)) begin
            int_code = nfc_pkg::FMT_HE2;
         end else if ((n4 > (n1 << 12)) && (n3 >= (n2 << 2))) begin
            int_code = nfc_pkg::FMT_HE4;
         end
      end

      // float limits scale with the number of counted doublewords
      lim4 = LIM_W'(snap_cnt_ff >> 1) + (LIM_W'(snap_cnt_ff >> 1) << 1);
      lim8 = lim4 >> 1;
      for (int k = 0; k < 3; k++) begin
         hit[k]     = LIM_W'(snap_sgl_ff[k]) > lim4;
         hit[k + 3] = LIM_W'(snap_dbl_ff[k]) > lim8;
      end

      // exactly one float counter over its limit, else unknown
      flt_code = nfc_pkg::FMT_UNKNOWN;
      if ((hit != 6'd0) && ((hit & (hit - 6'd1)) == 6'd0)) begin
         if (hit[0])      flt_code = nfc_pkg::FMT_LF4;
         else if (hit[1]) flt_code = nfc_pkg::FMT_HF4;
         else if (hit[2]) flt_code = nfc_pkg::FMT_VAXF;
         else if (hit[3]) flt_code = nfc_pkg::FMT_LF8;
         else if (hit[4]) flt_code = nfc_pkg::FMT_HF8;
         else             flt_code = nfc_pkg::FMT_VAXG;
      end

      out_code_in = (int_code != nfc_pkg::FMT_UNKNOWN) ? int_code : flt_code;
   end

   // ------------------------------------------------------------------
   // Valid flags
   // ------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_load ? req_valid : s1_valid_ff;

      snap_valid_in = snap_valid_ff;
      if (out_load) snap_valid_in = 1'b0;
      if (s1_go && s1_last_ff) snap_valid_in = 1'b1;

      out_valid_in = out_load ? snap_valid_ff : out_valid_ff;
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         for (int k = 0; k < 4; k++) lane_ff[k] <= '0;
         for (int k = 0; k < 3; k++) begin
            sgl_ff[k] <= '0;
            dbl_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff   <= s1_valid_in;
         snap_valid_ff <= snap_valid_in;
         out_valid_ff  <= out_valid_in;
         if (s1_go) begin
            // last doubleword: hand the totals to the snapshot, start fresh
            if (s1_last_ff) begin
               cnt_ff <= '0;
               for (int k = 0; k < 4; k++) lane_ff[k] <= '0;
               for (int k = 0; k < 3; k++) begin
                  sgl_ff[k] <= '0;
                  dbl_ff[k] <= '0;
               end
            end else begin
               cnt_ff  <= cnt_in;
               lane_ff <= lane_in;
               sgl_ff  <= sgl_in;
               dbl_ff  <= dbl_in;
            end
         end
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_w0_ff   <= req_first_word;
         s1_w1_ff   <= req_second_word;
         s1_last_ff <= req_last_item;
      end
      if (s1_go && s1_last_ff) begin
         snap_cnt_ff  <= cnt_in;
         snap_lane_ff <= lane_in;
         snap_sgl_ff  <= sgl_in;
         snap_dbl_ff  <= dbl_in;
      end
      if (out_load) begin
         out_code_ff <= out_code_in;
      end
   end

endmodule

[tb/tb_numeric_format_classifier.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_numeric_format_classifier
// Streams buffers of doublewords into the classifier and checks every format
// code it returns against an in-bench tally of lane sums and exponent hits.
// The sequence is hand-built buffers for each format code and the field
// extremes, then random buffers. The random buffers have random lengths and
// layouts, broken and noise buffers among them. Both channels idle at random.
// One long result hold-off backs the block up, and the sender waits for the
// block to drain now and then.
// ----------------------------------------------------------------------------
module tb_numeric_format_classifier;

   localparam int MAX_DW         = 2048;  // doubleword limit handed to the block
   localparam int RANDOM_ITEMS   = 650;   // random requests before the trailing tail
   localparam int SQUEEZE_ITEMS  = 40;    // back-to-back single-request buffers
   localparam int HOLD_CYCLES    = 250;   // result hold-off during the squeeze
   localparam int TAIL_CYCLES    = 10;    // margin after the last transfer for results to arrive
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
   localparam int MAX_REPORTS    = 10;

   // Exponent windows: bias - 3 < e < bias + 20
   localparam int E4_LO = 127 - 3;
   localparam int E4_HI = 127 + 20;
   localparam int E8_LO = 1023 - 3;
   localparam int E8_HI = 1023 + 20;

   // Word layouts that the stimulus generator can produce
   typedef enum int {
      ST_LE2, ST_LE4, ST_HE2, ST_HE4,
      ST_LF4, ST_HF4, ST_VAXF, ST_LF8, ST_HF8, ST_VAXG,
      ST_NOISE
   } layout_type;

   typedef struct {
      logic [31:0] first;
      logic [31:0] second;
      logic        last;
      int          gap;    // idle cycles before the request is offered
      bit          drain;  // hold the request until every format code is back
      bit          hold;   // start the long result hold-off with this request
   } dword_req_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_first_word = '0;
   logic [31:0] req_second_word = '0;
   logic        req_last_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_format_code;

   numeric_format_classifier #(
      .MAX_DOUBLEWORDS(MAX_DW)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_first_word  (req_first_word),
      .req_second_word (req_second_word),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_format_code (rsp_format_code)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Format tally: lane sums and exponent hit counters at the block's widths
   // -------------------------------------------------------------------------
   logic [19:0] lane_total [4];
   logic [12:0] hit4 [3];   // little-endian, big-endian, VAX single
   logic [11:0] hit8 [3];   // little-endian, big-endian, VAX double
   logic [11:0] dw_seen;

   logic [3:0]     format_due [$];   // format codes still owed by the block
   dword_req_type  pending [$];      // requests not yet offered to the block

   int fault_count    = 0;
   int requests_total = 0;
   int requests_taken = 0;        // written by the driver, nonblocking
   int marks_sent     = 0;        // last_item requests accepted, nonblocking
   int results_seen   = 0;        // format codes accepted, nonblocking
   int squeeze_token  = 0;        // bumped by the driver to start the hold-off

   function automatic void log_fault(string what);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("ERROR @%0t: %s", $time, what);
   endfunction

   function automatic bit exp4_ok(logic [15:0] half);
      int e;
      e = int'(half[14:7]);
      return (e > E4_LO) && (e < E4_HI);
   endfunction

   function automatic bit exp8_ok(logic [15:0] half);
      int e;
      e = int'(half[14:4]);
      return (e > E8_LO) && (e < E8_HI);
   endfunction

   function automatic void clear_tally();
      for (int k = 0; k < 4; k++)
         lane_total[k] = '0;
      for (int k = 0; k < 3; k++) begin
         hit4[k] = '0;
         hit8[k] = '0;
      end
      dw_seen = '0;
   endfunction

   // Fold one 4-byte word into the tally. The upper word of a doubleword
   // carries the little-endian double exponent; the lower word carries the
   // big-endian and VAX ones.
   function automatic void absorb_word(logic [31:0] w, bit upper);
      logic [15:0] le_half, be_half, vx_half;
      le_half = w[31:16];
      be_half = {w[7:0], w[15:8]};
      vx_half = w[15:0];
      for (int k = 0; k < 4; k++)
         lane_total[k] = lane_total[k] + w[8*k +: 8];
      if (exp4_ok(le_half)) hit4[0] = hit4[0] + 1'b1;
      if (exp4_ok(be_half)) hit4[1] = hit4[1] + 1'b1;
      if (exp4_ok(vx_half)) hit4[2] = hit4[2] + 1'b1;
      if (upper) begin
         if (exp8_ok(le_half)) hit8[0] = hit8[0] + 1'b1;
      end else begin
         if (exp8_ok(be_half)) hit8[1] = hit8[1] + 1'b1;
         if (exp8_ok(vx_half)) hit8[2] = hit8[2] + 1'b1;
      end
   endfunction

   // Decision tree: integer byte-order tests first, then the float counters
   // when exactly one of them is over its limit.
   function automatic logic [3:0] pick_format();
      logic [63:0] n1, n2, n3, n4;
      int unsigned lim4, lim8;
      bit [5:0]    over;
      n1 = 64'(lane_total[0]);
      n2 = 64'(lane_total[1]);
      n3 = 64'(lane_total[2]);
      n4 = 64'(lane_total[3]);
      if (n1 > (n4 << 3)) begin
         if (n3 > (n2 << 3))
            return nfc_pkg::FMT_LE2;
         if (n1 > (n4 << 12) && n2 >= (n3 << 2))
            return nfc_pkg::FMT_LE4;
      end else if (n4 > (n1 << 3)) begin
         if (n2 > (n3 << 3))
            return nfc_pkg::FMT_HE2;
         if (n4 > (n1 << 12) && n3 >= (n2 << 2))
            return nfc_pkg::FMT_HE4;
      end
      lim4 = 3 * int'(dw_seen >> 1);
      lim8 = lim4 >> 1;
      over[0] = hit4[0] > lim4;
      over[1] = hit4[1] > lim4;
      over[2] = hit4[2] > lim4;
      over[3] = hit8[0] > lim8;
      over[4] = hit8[1] > lim8;
      over[5] = hit8[2] > lim8;
      if ($countones(over) != 1) return nfc_pkg::FMT_UNKNOWN;
      if (over[0]) return nfc_pkg::FMT_LF4;
      if (over[1]) return nfc_pkg::FMT_HF4;
      if (over[2]) return nfc_pkg::FMT_VAXF;
      if (over[3]) return nfc_pkg::FMT_LF8;
      if (over[4]) return nfc_pkg::FMT_HF8;
      return nfc_pkg::FMT_VAXG;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   function automatic void queue_dw(logic [31:0] first, logic [31:0] second, logic last,
                                    int gap, bit drain = 1'b0, bit hold = 1'b0);
      dword_req_type r;
      r.first  = first;
      r.second = second;
      r.last   = last;
      r.gap    = gap;
      r.drain  = drain;
      r.hold   = hold;
      pending.push_back(r);
   endfunction

   // Build one word in the given layout. Exponents are drawn a little past
   // both ends of the window so the boundaries get hit from either side.
   function automatic logic [31:0] make_word(layout_type style, bit upper);
      logic [31:0] noise, spin;
      logic [15:0] half4, half8;
      noise = $urandom;
      spin  = $urandom;
      half4 = {spin[0], 8'($urandom_range(E4_LO - 2, E4_HI + 2)), spin[7:1]};
      half8 = {spin[8], 11'($urandom_range(E8_LO - 2, E8_HI + 2)), spin[12:9]};
      case (style)
         ST_LE2:  return {6'd0, spin[17:16], noise[23:16], 6'd0, spin[19:18], noise[7:0]};
         ST_LE4:  return {8'h00, 6'd0, spin[17:16], noise[15:0]};
         ST_HE2:  return {noise[31:24], 6'd0, spin[17:16], noise[15:8], 6'd0, spin[19:18]};
         ST_HE4:  return {noise[31:16], 6'd0, spin[17:16], 8'h00};
         ST_LF4:  return {half4, noise[15:0]};
         ST_HF4:  return {noise[31:16], half4[7:0], half4[15:8]};
         ST_VAXF: return {noise[31:16], half4};
         ST_LF8:  return upper ? {half8, noise[15:0]} : noise;
         ST_HF8:  return upper ? noise : {noise[31:16], half8[7:0], half8[15:8]};
         ST_VAXG: return upper ? noise : {noise[31:16], half8};
         default: return noise;
      endcase
   endfunction

   function automatic layout_type any_layout();
      return layout_type'($urandom_range(0, int'(ST_NOISE)));
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: offer queued requests, honoring gaps, drain points and
   // the stall; a stalled request keeps its payload.
   // -------------------------------------------------------------------------
   dword_req_type next_req;
   int         gap_left   = 0;
   bit         gap_armed  = 1'b0;
   int         marks_here = 0;   // driver-local count of accepted last_item

   always @(posedge clock) begin
      if (reset) begin
         req_valid       <= 1'b0;
         req_first_word  <= '0;
         req_second_word <= '0;
         req_last_item   <= 1'b0;
         gap_armed = 1'b0;
         gap_left  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            requests_taken <= requests_taken + 1;
            if (req_last_item) begin
               marks_here++;
               marks_sent <= marks_here;
            end
         end
         // Only move on when nothing is held on the channel
         if (!req_valid || !req_stall) begin
            if (pending.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               if (!gap_armed) begin
                  gap_left  = pending[0].gap;
                  gap_armed = 1'b1;
               end
               if (gap_left > 0) begin
                  gap_left--;
                  req_valid <= 1'b0;
               end else if (pending[0].drain && marks_here != results_seen) begin
                  // wait for every outstanding format code before going on
                  req_valid <= 1'b0;
               end else begin
                  next_req  = pending.pop_front();
                  gap_armed = 1'b0;
                  req_valid       <= 1'b1;
                  req_first_word  <= next_req.first;
                  req_second_word <= next_req.second;
                  req_last_item   <= next_req.last;
                  if (next_req.hold)
                     squeeze_token <= squeeze_token + 1;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result receiver: random stall runs, short and long, with free stretches;
   // a squeeze request from the driver forces a long counted hold-off.
   // -------------------------------------------------------------------------
   int run_left     = 0;
   bit run_stall    = 1'b0;
   int hold_left    = 0;
   int squeeze_seen = 0;

   always @(posedge clock) begin
      int roll;
      if (reset) begin
         rsp_stall <= 1'b0;
         run_left  = 0;
         hold_left = 0;
      end else if (squeeze_token != squeeze_seen) begin
         squeeze_seen = squeeze_token;
         hold_left    = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (run_left == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               run_stall = 1'b0;
               run_left  = $urandom_range(1, 12);
            end else if (roll < 85) begin
               run_stall = 1'b1;
               run_left  = $urandom_range(1, 3);
            end else if (roll < 95) begin
               run_stall = 1'b0;   // stretch with no stalls at all
               run_left  = $urandom_range(20, 80);
            end else begin
               run_stall = 1'b1;
               run_left  = $urandom_range(20, 60);
            end
         end
         run_left--;
         rsp_stall <= run_stall;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: check each accepted format code first, then fold the accepted
   // request into the tally so the order within the edge is fixed.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [3:0] want;
      if (reset) begin
         clear_tally();
         results_seen <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (format_due.size() == 0) begin
               log_fault($sformatf("format code %0d with none pending", rsp_format_code));
            end else begin
               want = format_due.pop_front();
               if (rsp_format_code !== want)
                  log_fault($sformatf("format_code expected %0d, got %0d",
                                      want, rsp_format_code));
            end
         end
         if (req_valid && !req_stall) begin
            // past the limit a doubleword adds nothing, but a marker still counts
            if (dw_seen < MAX_DW) begin
               absorb_word(req_first_word, 1'b0);
               absorb_word(req_second_word, 1'b1);
               dw_seen = dw_seen + 1'b1;
            end
            if (req_last_item) begin
               format_due.push_back(pick_format());
               clear_tally();
            end
         end
      end
   end

   // Watchdog: end the run when neither channel has moved for too long
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      layout_type style;
      int      len;
      int      random_done;
      bit      mixed, burst, drain_next, squeezed;

      // One-doubleword buffers, each aimed at one format code
      queue_dw(32'h007F_007F, 32'h007F_007F, 1'b1, draw_gap());   // 16-bit little-endian
      queue_dw(32'h0000_00FF, 32'h0000_00FF, 1'b1, draw_gap());   // 32-bit little-endian
      queue_dw(32'h7F00_7F00, 32'h7F00_7F00, 1'b1, draw_gap());   // 16-bit big-endian
      queue_dw(32'hFF00_0000, 32'hFF00_0000, 1'b1, draw_gap());   // 32-bit big-endian
      queue_dw(32'h4612_2010, 32'h4612_2010, 1'b1, draw_gap());   // little-endian single
      queue_dw(32'h1020_1246, 32'h1020_1246, 1'b1, draw_gap());   // big-endian single
      queue_dw(32'h2010_4612, 32'h2010_4612, 1'b1, draw_gap());   // VAX single
      // Doubles need two doublewords so the single counters stay under limit
      queue_dw(32'h2010_2010, 32'h4065_2010, 1'b0, draw_gap());
      queue_dw(32'h2010_2010, 32'h4065_2010, 1'b1, draw_gap());   // little-endian double
      queue_dw(32'h2010_6540, 32'h2010_2010, 1'b0, draw_gap());
      queue_dw(32'h2010_6540, 32'h2010_2010, 1'b1, draw_gap());   // big-endian double
      queue_dw(32'h2010_4065, 32'h2010_2010, 1'b0, draw_gap());
      queue_dw(32'h2010_4065, 32'h2010_2010, 1'b1, draw_gap());   // VAX double
      // Two float counters over their limit at once: unknown
      queue_dw(32'h4612_4612, 32'h4612_4612, 1'b1, draw_gap());
      // Field extremes
      queue_dw(32'h0000_0000, 32'h0000_0000, 1'b1, draw_gap());
      queue_dw(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, draw_gap());
      queue_dw(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, draw_gap());
      queue_dw(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, draw_gap());

      // Random buffers; a third of the way in, back the block up
      random_done = 0;
      drain_next  = 1'b1;
      squeezed    = 1'b0;
      while (random_done < RANDOM_ITEMS) begin
         if (!squeezed && random_done >= RANDOM_ITEMS / 3) begin
            // drain first, then flood single-doubleword buffers while the
            // receiver holds off, and drain again afterwards
            for (int k = 0; k < SQUEEZE_ITEMS; k++)
               queue_dw(make_word(any_layout(), 1'b0), make_word(any_layout(), 1'b1),
                        1'b1, 0, k == 0, k == 0);
            squeezed   = 1'b1;
            drain_next = 1'b1;
         end
         style = any_layout();
         case ($urandom_range(0, 19))
            0:             len = $urandom_range(41, 100);
            1, 2, 3, 4, 5: len = $urandom_range(13, 40);
            default:       len = $urandom_range(1, 12);
         endcase
         mixed = $urandom_range(0, 99) < 15;   // broken buffer: layout per doubleword
         burst = $urandom_range(0, 3) == 0;
         for (int k = 0; k < len; k++) begin
            if (mixed)
               style = any_layout();
            queue_dw(make_word(style, 1'b0), make_word(style, 1'b1), k == len - 1,
                     burst ? 0 : draw_gap(), k == 0 && drain_next);
         end
         drain_next  = $urandom_range(0, 19) == 0;
         random_done += len;
      end

      // Trailing doublewords with no marker: accepted, nothing comes back
      for (int k = 0; k < 5; k++)
         queue_dw($urandom, $urandom, 1'b0, draw_gap());

      requests_total = pending.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (requests_taken != requests_total || marks_sent != results_seen);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (format_due.size() != 0)
         log_fault($sformatf("%0d format codes never arrived", format_due.size()));

      if (fault_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
